/* rtl/sensor_frame_crc_convert_macros.svh */
// assertion macros used by the top-level rtl
`ifndef SENSOR_FRAME_CRC_CONVERT_MACROS_SVH
`define SENSOR_FRAME_CRC_CONVERT_MACROS_SVH

// condition that must hold at every edge outside reset
`define SCF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define SCF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/scf_pkg.sv */
package scf_pkg;

	// crc-8 parameters
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_MSB  = 8'h80;

	// conversion constants
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [13:0] HUM_SPAN    = 14'd12500;
	localparam logic [15:0] HUM_OFFSET  = 16'd600;
	localparam logic [13:0] HUM_MAX     = 14'd10000;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;

	// byte position inside the six-byte reply
	typedef enum logic [2:0] {
		POS_T_MSB = 3'd0,
		POS_T_LSB = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_MSB = 3'd3,
		POS_H_LSB = 3'd4,
		POS_H_CRC = 3'd5
	} scf_pos_t;

	// decoded frame handed to the conversion pipeline
	typedef struct packed {
		logic        good;
		logic [15:0] traw;
		logic [15:0] hraw;
	} scf_frame_t;

	// one byte of crc-8, msb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 8'd0) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(p / 65535) for p below 65535 * 32768
	function automatic logic [14:0] div_full_scale(input logic [30:0] p);
		logic [14:0] q0;
		logic [16:0] r;
		q0 = p[30:16];
		r  = {1'b0, p[15:0]} + {2'b00, q0};
		if (r >= FULL_SCALE) begin
			return q0 + 15'd1;
		end
		return q0;
	endfunction

endpackage

/* rtl/scf_frame.sv */
module scf_frame import scf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_valid,
	output logic       s_ready,
	input  logic [7:0] s_byte,
	input  logic       s_start,
	output logic       f_valid,
	input  logic       f_ready,
	output scf_frame_t f_data
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	scf_pos_t    pos_q, pos_eff, pos_d;
	logic [7:0]  crc_q, crc_d;
	logic [15:0] tword_q, tword_d;
	logic        tgood_q, tgood_d;
	logic [7:0]  hhigh_q, hhigh_d;
	logic [7:0]  hlow_q, hlow_d;
	logic        is_last;
	logic        s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_ready) begin
			v_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			byte_s1  <= s_byte;
			start_s1 <= s_start;
		end
	end

	// a start flag or an unused code restarts at the temperature msb
	always_comb begin
		pos_eff = pos_q;
		if (start_s1 || pos_q > POS_H_CRC) begin
			pos_eff = POS_T_MSB;
		end
	end

	assign is_last = (pos_eff == POS_H_CRC);
	assign s1_go   = v_s1 && (!is_last || f_ready);
	assign s_ready = !v_s1 || s1_go;

	// next position
	always_comb begin
		unique case (pos_eff)
			POS_T_MSB: pos_d = POS_T_LSB;
			POS_T_LSB: pos_d = POS_T_CRC;
			POS_T_CRC: pos_d = POS_H_MSB;
			POS_H_MSB: pos_d = POS_H_LSB;
			POS_H_LSB: pos_d = POS_H_CRC;
			POS_H_CRC: pos_d = POS_T_MSB;
			default:   pos_d = POS_T_MSB;
		endcase
	end

	// crc and word updates per position
	always_comb begin
		crc_d   = crc_q;
		tword_d = tword_q;
		tgood_d = tgood_q;
		hhigh_d = hhigh_q;
		hlow_d  = hlow_q;
		unique case (pos_eff)
			POS_T_MSB: begin
				crc_d   = crc8_byte(CRC_INIT, byte_s1);
				tword_d = {byte_s1, 8'd0};
			end
			POS_T_LSB: begin
				crc_d   = crc8_byte(crc_q, byte_s1);
				tword_d = {tword_q[15:8], byte_s1};
			end
			POS_T_CRC: begin
				tgood_d = (crc_q == byte_s1);
				crc_d   = CRC_INIT;
			end
			POS_H_MSB: begin
				crc_d   = crc8_byte(CRC_INIT, byte_s1);
				hhigh_d = byte_s1;
			end
			POS_H_LSB: begin
				crc_d  = crc8_byte(crc_q, byte_s1);
				hlow_d = byte_s1;
			end
			POS_H_CRC: begin
				crc_d = CRC_INIT;
			end
			default: begin
				crc_d = CRC_INIT;
			end
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_T_MSB;
			crc_q   <= CRC_INIT;
			tword_q <= 16'd0;
			tgood_q <= 1'b0;
			hhigh_q <= 8'd0;
			hlow_q  <= 8'd0;
		end else if (s1_go) begin
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			tword_q <= tword_d;
			tgood_q <= tgood_d;
			hhigh_q <= hhigh_d;
			hlow_q  <= hlow_d;
		end
	end

	// completed frame on the humidity crc byte
	assign f_valid     = v_s1 && is_last;
	assign f_data.good = tgood_q && (crc_q == byte_s1);
	assign f_data.traw = tword_q;
	assign f_data.hraw = {hhigh_q, hlow_q};

endmodule

/* rtl/scf_conv.sv */
module scf_conv import scf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        f_valid,
	output logic        f_ready,
	input  scf_frame_t  f_data,
	output logic        m_valid,
	input  logic        m_ready,
	output logic        good,
	output logic [14:0] temp,
	output logic [13:0] hum
);

	logic        v_s2, v_s3, v_q;
	scf_frame_t  frm_s2;
	logic        good_s3;
	logic [30:0] tprod_s3;
	logic [30:0] hprod_s3;
	logic        good_q;
	logic [14:0] temp_q;
	logic [13:0] hum_q;
	logic        out_rdy, s3_rdy;

	logic [14:0] tq, hq;
	logic [15:0] tdiff, hdiff;
	logic [14:0] temp_d;
	logic [13:0] hum_d;

	// stage ready chain
	assign out_rdy = !v_q || m_ready;
	assign s3_rdy  = !v_s3 || out_rdy;
	assign f_ready = !v_s2 || s3_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (f_ready) v_s2 <= f_valid;
			if (s3_rdy)  v_s3 <= v_s2;
			if (out_rdy) v_q  <= v_s3;
		end
	end

	// frame register
	always_ff @(posedge clk) begin
		if (f_valid && f_ready) begin
			frm_s2 <= f_data;
		end
	end

	// scale both raw words
	always_ff @(posedge clk) begin
		if (v_s2 && s3_rdy) begin
			good_s3  <= frm_s2.good;
			tprod_s3 <= 31'(frm_s2.traw) * 31'(TEMP_SPAN);
			hprod_s3 <= 31'(frm_s2.hraw) * 31'(HUM_SPAN);
		end
	end

	// divide by full scale, offset, clamp humidity
	always_comb begin
		tq    = div_full_scale(tprod_s3);
		hq    = div_full_scale(hprod_s3);
		tdiff = {1'b0, tq} - TEMP_OFFSET;
		hdiff = {1'b0, hq} - HUM_OFFSET;
		temp_d = 15'd0;
		hum_d  = 14'd0;
		if (good_s3) begin
			temp_d = tdiff[14:0];
			priority if (hdiff[15]) begin
				hum_d = 14'd0;
			end else if (hdiff > {2'b00, HUM_MAX}) begin
				hum_d = HUM_MAX;
			end else begin
				hum_d = hdiff[13:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (v_s3 && out_rdy) begin
			good_q <= good_s3;
			temp_q <= temp_d;
			hum_q  <= hum_d;
		end
	end

	assign m_valid = v_q;
	assign good    = good_q;
	assign temp    = temp_q;
	assign hum     = hum_q;

endmodule

/* rtl/sensor_frame_crc_convert.sv */
// Decodes the six-byte measurement reply of a temperature and humidity sensor, one byte per
// item: temperature msb, lsb, crc, humidity msb, lsb, crc, each crc being crc-8 (poly 0x31,
// init 0xff) over its word. A high tuser on an input item restarts the frame at that byte.
// After the sixth byte one result item comes out: tuser is the good flag (both crcs match),
// tdata holds temperature in 0.01 degC (two's complement, -4500 + floor(17500*raw/65535))
// and humidity in 0.01 %RH (-600 + floor(12500*raw/65535), clamped to 0..10000); both are
// zero when the frame is bad. The block takes one byte every cycle unless the sixth byte waits
// on a full pipeline, each crc update being combinational into the frame state register. A
// result passes the input, frame and scaling multiply registers, then divide and clamp, into
// the result register. Output backpressure only stops the input when the pipeline is full.
`include "sensor_frame_crc_convert_macros.svh"

module sensor_frame_crc_convert import scf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
	output logic        m_axis_tuser    // [0] frame_good
);

	logic        f_valid;
	logic        f_ready;
	scf_frame_t  f_data;
	logic [14:0] temp;
	logic [13:0] hum;

	// byte assembly and crc check
	scf_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_byte  (s_axis_tdata),
		.s_start (s_axis_tuser),
		.f_valid (f_valid),
		.f_ready (f_ready),
		.f_data  (f_data)
	);

	// unit conversion
	scf_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.f_valid (f_valid),
		.f_ready (f_ready),
		.f_data  (f_data),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.good    (m_axis_tuser),
		.temp    (temp),
		.hum     (hum)
	);

	// pack result item
	assign m_axis_tdata = {3'd0, hum, temp};

	// checks
	`SCF_ASSERT_IMP(a_bad_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[28:0] == 29'd0, "bad frame with nonzero readings")
	`SCF_ASSERT_IMP(a_hum_range, m_axis_tvalid, m_axis_tdata[28:15] <= HUM_MAX, "humidity above full range")
	`SCF_ASSERT_NEXT(a_frame_hold, f_valid && !f_ready, f_valid && $stable(f_data), "frame result lost while stalled")

endmodule
